// ===== rtl/mdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus drive command framer package
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mdcf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int BODY_LEN  = 6;

    // Function codes on the wire
    localparam logic [7:0]  FC_READ      = 8'h03;
    localparam logic [7:0]  FC_WRITE     = 8'h06;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  PERCENT_MAX  = 8'd100;
    localparam logic [15:0] SPEED_SCALE  = 16'd100;
    localparam logic [15:0] READ_COUNT   = 16'h0001;

    // Command codes
    localparam logic [1:0] FUNC_STATUS = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_SPEED  = 2'd2;
    localparam logic [1:0] FUNC_STOP   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEVICE_ADDRESS   = 3'd0;
    localparam logic [2:0] CFG_CONTROL_REGISTER = 3'd1;
    localparam logic [2:0] CFG_SPEED_REGISTER   = 3'd2;
    localparam logic [2:0] CFG_STATUS_REGISTER  = 3'd3;
    localparam logic [2:0] CFG_RUN_CODE         = 3'd4;
    localparam logic [2:0] CFG_HALT_CODE        = 3'd5;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_DEVICE_ADDRESS   = 8'd1;
    localparam logic [15:0] RST_CONTROL_REGISTER = 16'd7680;
    localparam logic [15:0] RST_SPEED_REGISTER   = 16'd7681;
    localparam logic [15:0] RST_STATUS_REGISTER  = 16'd7682;
    localparam logic [15:0] RST_RUN_CODE         = 16'd5;
    localparam logic [15:0] RST_HALT_CODE        = 16'd6;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] percent;
    } cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [2:0] byte_position;
        logic       last_byte;
    } res_t;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [15:0] control_register;
        logic [15:0] speed_register;
        logic [15:0] status_register;
        logic [15:0] run_code;
        logic [15:0] halt_code;
    } cfg_t;

    // Frame body handed from the builder to the serialiser; entry 0 goes first.
    typedef struct packed {
        logic                           valid;
        logic [BODY_LEN-1:0][7:0]       body;
    } frame_t;

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/mdcf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the six framer registers and takes writes from the config channel.
// ----------------------------------------------------------------------------
module mdcf_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output mdcf_pkg::cfg_t     cfg
);
    import mdcf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken at once.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS:   cfg_next.device_address   = cfg_data[7:0];
                CFG_CONTROL_REGISTER: cfg_next.control_register = cfg_data;
                CFG_SPEED_REGISTER:   cfg_next.speed_register   = cfg_data;
                CFG_STATUS_REGISTER:  cfg_next.status_register  = cfg_data;
                CFG_RUN_CODE:         cfg_next.run_code         = cfg_data;
                CFG_HALT_CODE:        cfg_next.halt_code        = cfg_data;
                default:              cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address   <= RST_DEVICE_ADDRESS;
            cfg_reg.control_register <= RST_CONTROL_REGISTER;
            cfg_reg.speed_register   <= RST_SPEED_REGISTER;
            cfg_reg.status_register  <= RST_STATUS_REGISTER;
            cfg_reg.run_code         <= RST_RUN_CODE;
            cfg_reg.halt_code        <= RST_HALT_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mdcf_builder.sv =====
// ----------------------------------------------------------------------------
// Frame builder
// Registers an accepted command and forms the six-byte frame body from it.
// ----------------------------------------------------------------------------
module mdcf_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mdcf_pkg::cmd_t     cmd,
    input  mdcf_pkg::cfg_t     cfg,
    input  logic               ser_ready,
    output mdcf_pkg::frame_t   frame
);
    import mdcf_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    cmd_t        cmd_reg;
    logic        accept;
    logic [7:0]  pct_clamped;
    logic [7:0]  fc;
    logic [15:0] reg_addr;
    logic [15:0] value;

    // A held command leaves for the serialiser in the same cycle a new one arrives.
    assign busy   = in_valid_reg && !ser_ready;
    assign accept = start && !busy;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (ser_ready)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_reg <= '0;
        else if (accept)
            cmd_reg <= cmd;
    end

    assign pct_clamped = (cmd_reg.percent > PERCENT_MAX) ? PERCENT_MAX : cmd_reg.percent;

    always_comb
    begin
        unique case (cmd_reg.func)
            FUNC_STATUS:
            begin
                fc       = FC_READ;
                reg_addr = cfg.status_register;
                value    = READ_COUNT;
            end
            FUNC_START:
            begin
                fc       = FC_WRITE;
                reg_addr = cfg.control_register;
                value    = cfg.run_code;
            end
            FUNC_SPEED:
            begin
                fc       = FC_WRITE;
                reg_addr = cfg.speed_register;
                value    = 16'({8'h00, pct_clamped} * SPEED_SCALE);
            end
            FUNC_STOP:
            begin
                fc       = FC_WRITE;
                reg_addr = cfg.control_register;
                value    = cfg.halt_code;
            end
        endcase
    end

    always_comb
    begin
        frame.valid   = in_valid_reg;
        frame.body[0] = cfg.device_address;
        frame.body[1] = fc;
        frame.body[2] = reg_addr[15:8];
        frame.body[3] = reg_addr[7:0];
        frame.body[4] = value[15:8];
        frame.body[5] = value[7:0];
    end

endmodule

// ===== rtl/mdcf_serializer.sv =====
// ----------------------------------------------------------------------------
// Frame serialiser
// Sends the frame body a byte per cycle while folding each byte into the
// CRC, then sends the CRC low byte and high byte.
// ----------------------------------------------------------------------------
module mdcf_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  mdcf_pkg::frame_t   frame,
    output logic               ser_ready,
    output logic               strobe,
    output mdcf_pkg::res_t     result
);
    import mdcf_pkg::*;

    localparam logic [2:0] POS_CRC_LO = 3'(BODY_LEN);
    localparam logic [2:0] POS_LAST   = 3'(FRAME_LEN - 1);

    logic                     active_reg;
    logic                     active_next;
    logic [2:0]               pos_reg;
    logic [2:0]               pos_next;
    logic [BODY_LEN-1:0][7:0] body_reg;
    logic [BODY_LEN-1:0][7:0] body_next;
    logic [15:0]              crc_reg;
    logic [15:0]              crc_next;
    logic                     strobe_reg;
    logic                     strobe_next;
    res_t                     result_reg;
    res_t                     result_next;
    logic                     load;
    logic [7:0]               out_byte;

    // Free now, or sending the last byte of the current frame this cycle.
    assign ser_ready = !active_reg || (pos_reg == POS_LAST);
    assign load      = frame.valid && ser_ready;

    always_comb
    begin
        priority if (pos_reg == POS_CRC_LO)
            out_byte = crc_reg[7:0];
        else if (pos_reg == POS_LAST)
            out_byte = crc_reg[15:8];
        else
            out_byte = body_reg[0];
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        body_next   = body_reg;
        crc_next    = crc_reg;
        priority if (load) begin
            active_next = 1'b1;
            pos_next    = 3'd0;
            body_next   = frame.body;
            crc_next    = CRC_INIT;
        end else if (active_reg) begin
            active_next = (pos_reg != POS_LAST);
            pos_next    = pos_reg + 3'd1;
            body_next   = {8'h00, body_reg[BODY_LEN-1:1]};
            if (pos_reg < POS_CRC_LO)
                crc_next = crc16_update(crc_reg, body_reg[0]);
        end
    end

    always_comb
    begin
        strobe_next               = active_reg;
        result_next.frame_byte    = out_byte;
        result_next.byte_position = pos_reg;
        result_next.last_byte     = (pos_reg == POS_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            pos_reg    <= 3'd0;
            strobe_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg   <= body_next;
        crc_reg    <= crc_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== rtl/modbus_drive_command_framer_top.sv =====
// ----------------------------------------------------------------------------
// Modbus drive command framer
// Turns drive commands into eight-byte Modbus RTU frames with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// A command word (read status, start, set speed, stop, plus a speed percent)
// is taken on a rising edge where start is high and busy is low. Each command
// yields eight result words, one per cycle, on result with strobe high:
// address, function code, register address and value high byte first, then
// the CRC low and high bytes; last_byte marks the CRC high byte.
// With no frame going out, a taken command is registered in the builder, loaded
// into the serialiser and its first byte registered onto result; a command taken
// while a frame is going out waits for that frame. The eight bytes follow without
// gaps. Frames can follow back to back; the one-byte-per-cycle result port sets
// the rate at which commands are taken.
// The receiver cannot stall the result words; each is valid for one cycle.
// Configuration words arrive on cfg_valid/cfg_index/cfg_data and are always
// accepted; they should only be sent while no frame is in flight.
// Reset clears all pending work and restores the register defaults.
// ----------------------------------------------------------------------------
module modbus_drive_command_framer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mdcf_pkg::cmd_t     cmd,
    output logic               strobe,
    output mdcf_pkg::res_t     result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import mdcf_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    logic   ser_ready;

    mdcf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdcf_builder u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg       (cfg),
        .ser_ready (ser_ready),
        .frame     (frame)
    );

    mdcf_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .ser_ready (ser_ready),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

// ===== test/mdcf_checker.sv =====
// ----------------------------------------------------------------------------
// Modbus drive command framer checker
// Watches the command, result and configuration channels, works out the
// frame every accepted command should produce and compares it word by word.
// ----------------------------------------------------------------------------
module mdcf_checker
    import mdcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        strobe,
    input  res_t        result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          words_due
);

    cfg_t regs;
    res_t frame_words_due[$];

    initial errors = 0;

    function automatic logic [15:0] modbus_crc(input logic [47:0] body);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < BODY_LEN; i++) begin
            crc = crc ^ {8'h00, body[47 - 8 * i -: 8]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // Appends the eight words of the frame that this command should produce.
    function automatic void queue_frame(input cmd_t c);
        logic [7:0]  fc;
        logic [15:0] reg_addr;
        logic [15:0] value;
        logic [7:0]  pct;
        logic [15:0] crc;
        logic [63:0] frame;
        res_t        w;
        fc = FC_WRITE;
        reg_addr = regs.control_register;
        value = regs.halt_code;
        case (c.func)
            FUNC_STATUS:
            begin
                fc = FC_READ;
                reg_addr = regs.status_register;
                value = READ_COUNT;
            end
            FUNC_START:
            begin
                value = regs.run_code;
            end
            FUNC_SPEED:
            begin
                pct = (c.percent > PERCENT_MAX) ? PERCENT_MAX : c.percent;
                reg_addr = regs.speed_register;
                value = {8'h00, pct} * SPEED_SCALE;
            end
            default:
            begin
                value = regs.halt_code;
            end
        endcase
        crc = modbus_crc({regs.device_address, fc, reg_addr, value});
        // The CRC goes out low byte first, unlike the other fields.
        frame = {regs.device_address, fc, reg_addr, value, crc[7:0], crc[15:8]};
        for (int k = 0; k < FRAME_LEN; k++) begin
            w.frame_byte = frame[63 - 8 * k -: 8];
            w.byte_position = 3'(k);
            w.last_byte = (k == FRAME_LEN - 1);
            frame_words_due.push_back(w);
        end
    endfunction

    task automatic report(input string msg);
        $display("mdcf_checker: %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_word(input res_t got);
        res_t want;
        if (frame_words_due.size() == 0) begin
            report($sformatf("result word %h with no frame byte due", got));
        end
        else begin
            want = frame_words_due.pop_front();
            if (got.frame_byte !== want.frame_byte)
                report($sformatf("frame_byte %h, want %h at position %0d",
                                 got.frame_byte, want.frame_byte, want.byte_position));
            if (got.byte_position !== want.byte_position)
                report($sformatf("byte_position %0d, want %0d",
                                 got.byte_position, want.byte_position));
            if (got.last_byte !== want.last_byte)
                report($sformatf("last_byte %b, want %b at position %0d",
                                 got.last_byte, want.last_byte, want.byte_position));
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            regs.device_address   = RST_DEVICE_ADDRESS;
            regs.control_register = RST_CONTROL_REGISTER;
            regs.speed_register   = RST_SPEED_REGISTER;
            regs.status_register  = RST_STATUS_REGISTER;
            regs.run_code         = RST_RUN_CODE;
            regs.halt_code        = RST_HALT_CODE;
            frame_words_due.delete();
            words_due <= 0;
        end
        else begin
            if (strobe !== 1'b0)
                check_word(result);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS:   regs.device_address   = cfg_data[7:0];
                    CFG_CONTROL_REGISTER: regs.control_register = cfg_data;
                    CFG_SPEED_REGISTER:   regs.speed_register   = cfg_data;
                    CFG_STATUS_REGISTER:  regs.status_register  = cfg_data;
                    CFG_RUN_CODE:         regs.run_code         = cfg_data;
                    CFG_HALT_CODE:        regs.halt_code        = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                queue_frame(cmd);
            words_due <= frame_words_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Modbus drive command framer testbench
// Drives directed and random drive commands through several register
// settings, with random sender gaps, while the checker compares every frame.
// ----------------------------------------------------------------------------
module tb_top;
    import mdcf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        strobe;
    res_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          words_due;
    int          quiet_cycles;
    bit          calm;

    modbus_drive_command_framer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mdcf_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .words_due (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ends the run once nothing has moved on any channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.func = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
            0:       c.percent = 8'($urandom_range(0, 100));
            1:       c.percent = 8'($urandom_range(98, 103));
            default: c.percent = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [15:0] random_reg_value();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Start stays high after acceptance so that the next word can follow at once.
    task automatic issue(input cmd_t c);
        cmd <= c;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        cmd <= random_cmd();
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the sender off until every frame byte has come out.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (words_due != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic load_config(input cfg_t v);
        settle();
        write_reg(CFG_DEVICE_ADDRESS, {8'($urandom_range(0, 255)), v.device_address});
        write_reg(CFG_CONTROL_REGISTER, v.control_register);
        // Indexes past the end of the register list must leave everything alone.
        write_reg(3'd6, 16'($urandom_range(0, 65535)));
        write_reg(CFG_SPEED_REGISTER, v.speed_register);
        write_reg(CFG_STATUS_REGISTER, v.status_register);
        write_reg(3'd7, 16'($urandom_range(0, 65535)));
        write_reg(CFG_RUN_CODE, v.run_code);
        write_reg(CFG_HALT_CODE, v.halt_code);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cfg_t setting;
        int   phase;
        int   n;
        calm = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every command, the percent extremes and the clamp edge.
        issue(cmd_t'{FUNC_STATUS, 8'd0});
        issue(cmd_t'{FUNC_STATUS, 8'd255});
        issue(cmd_t'{FUNC_START, 8'd0});
        pause_sender(3);
        issue(cmd_t'{FUNC_START, 8'd255});
        issue(cmd_t'{FUNC_SPEED, 8'd0});
        issue(cmd_t'{FUNC_SPEED, 8'd1});
        issue(cmd_t'{FUNC_SPEED, 8'd99});
        issue(cmd_t'{FUNC_SPEED, 8'd100});
        pause_sender(1);
        issue(cmd_t'{FUNC_SPEED, 8'd101});
        issue(cmd_t'{FUNC_SPEED, 8'd255});
        issue(cmd_t'{FUNC_SPEED, 8'd170});
        issue(cmd_t'{FUNC_SPEED, 8'd85});
        issue(cmd_t'{FUNC_STOP, 8'd255});
        issue(cmd_t'{FUNC_STOP, 8'd0});

        load_config('1);
        issue(cmd_t'{FUNC_STATUS, 8'd0});
        issue(cmd_t'{FUNC_START, 8'd0});
        issue(cmd_t'{FUNC_SPEED, 8'd255});
        issue(cmd_t'{FUNC_STOP, 8'd0});

        load_config('0);
        issue(cmd_t'{FUNC_STATUS, 8'd255});
        issue(cmd_t'{FUNC_START, 8'd255});
        issue(cmd_t'{FUNC_SPEED, 8'd100});
        issue(cmd_t'{FUNC_STOP, 8'd255});

        for (phase = 0; phase < 6; phase++)
        begin
            calm = (phase == 5);
            setting.device_address   = 8'(random_reg_value());
            setting.control_register = random_reg_value();
            setting.speed_register   = random_reg_value();
            setting.status_register  = random_reg_value();
            setting.run_code         = random_reg_value();
            setting.halt_code        = random_reg_value();
            load_config(setting);
            for (n = 0; n < 70; n++)
            begin
                issue(random_cmd());
                if (!calm)
                begin
                    if ((phase == 1 && n == 35) || $urandom_range(0, 59) == 0)
                        settle();
                    else if ($urandom_range(0, 3) == 0)
                        pause_sender($urandom_range(1, 19));
                end
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
